FILE: design/pcep_pkg.sv
// Shared types and constants for the prime count block.
`timescale 1ns / 1ps

package pcep_pkg;

    localparam int PCEP_MAX_ITEMS = 65536;
    localparam int PCEP_MAG_W     = 31;
    localparam int PCEP_DIV_W     = 16;
    localparam int PCEP_CNT_W     = 16;
    localparam int PCEP_STEP_W    = 5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_DONE
    } pcep_state_t;

    typedef struct packed {
        logic                  start;
        logic [PCEP_MAG_W-1:0] dividend;
        logic [PCEP_DIV_W-1:0] divisor;
    } rem_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic zero;
    } rem_stat_t;

endpackage

FILE: design/pcep_rem_unit.sv
// Bit-serial restoring remainder unit, one dividend bit per cycle.
`timescale 1ns / 1ps

module pcep_rem_unit
    import pcep_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  rem_ctrl_t ctrl,
    output rem_stat_t stat
);

    localparam logic [PCEP_STEP_W-1:0] LAST_STEP = PCEP_STEP_W'(PCEP_MAG_W - 1);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [PCEP_STEP_W-1:0] step_reg, step_next;
    logic [PCEP_DIV_W-1:0]  rem_reg, rem_next;
    logic [PCEP_MAG_W-1:0]  dvd_reg, dvd_next;
    logic [PCEP_DIV_W-1:0]  dsr_reg, dsr_next;
    logic [PCEP_DIV_W:0]    trial;
    logic [PCEP_DIV_W:0]    diff;

    always_comb
    begin
        trial     = {rem_reg, dvd_reg[PCEP_MAG_W-1]};
        diff      = trial - {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        if (busy_reg)
        begin
            // subtract when the trial remainder reaches the divisor
            if (trial >= {1'b0, dsr_reg})
                rem_next = diff[PCEP_DIV_W-1:0];
            else
                rem_next = trial[PCEP_DIV_W-1:0];
            dvd_next  = {dvd_reg[PCEP_MAG_W-2:0], 1'b0};
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (ctrl.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            dvd_next  = ctrl.dividend;
            dsr_next  = ctrl.divisor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign stat.zero = (rem_reg == '0);

endmodule

FILE: design/prime_count_even_positions.sv
// Top level: trial-division primality test with even-position prime count.
// Zero, negative, 0 or 1 go from idle straight to the done state, which loads the
// output register once it is free. Otherwise each trial divisor takes a square check,
// 31 remainder steps in the shared bit-serial unit and a result step; up to 46339
// divisors are tried. One item at a time; in_ready only when idle.
// Reset clears both counters, the sequencer and the output valid flag.
`timescale 1ns / 1ps

module prime_count_even_positions
    import pcep_pkg::*;
#(
    parameter int MAX_ITEMS = PCEP_MAX_ITEMS
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [31:0]           value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         is_prime,
    output logic        [PCEP_CNT_W-1:0] position,
    output logic        [PCEP_CNT_W-1:0] prime_count,
    output logic                         list_end
);

    localparam logic [PCEP_CNT_W-1:0] POS_LIMIT =
        ((MAX_ITEMS - 1) > 65535) ? {PCEP_CNT_W{1'b1}} : PCEP_CNT_W'(MAX_ITEMS - 1);
    localparam logic [PCEP_CNT_W-1:0] CNT_MAX = {PCEP_CNT_W{1'b1}};

    pcep_state_t             state_reg, state_next;
    logic [PCEP_MAG_W-1:0]   mag_reg, mag_next;
    logic [PCEP_DIV_W-1:0]   div_reg, div_next;
    logic [31:0]             sq_reg, sq_next;
    logic                    prime_reg, prime_next;
    logic                    end_reg, end_next;
    logic [PCEP_CNT_W-1:0]   pos_reg, pos_next;
    logic [PCEP_CNT_W-1:0]   total_reg, total_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    out_prime_reg, out_prime_next;
    logic [PCEP_CNT_W-1:0]   out_pos_reg, out_pos_next;
    logic [PCEP_CNT_W-1:0]   out_cnt_reg, out_cnt_next;
    logic                    out_end_reg, out_end_next;
    logic [PCEP_CNT_W-1:0]   total_inc;
    rem_ctrl_t               rem_ctrl;
    rem_stat_t               rem_stat;

    pcep_rem_unit u_rem
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (rem_ctrl),
        .stat  (rem_stat)
    );

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        div_next       = div_reg;
        sq_next        = sq_reg;
        prime_next     = prime_reg;
        end_next       = end_reg;
        pos_next       = pos_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_prime_next = out_prime_reg;
        out_pos_next   = out_pos_reg;
        out_cnt_next   = out_cnt_reg;
        out_end_next   = out_end_reg;
        rem_ctrl.start    = 1'b0;
        rem_ctrl.dividend = mag_reg;
        rem_ctrl.divisor  = div_reg;
        total_inc = (prime_reg && !pos_reg[0] && (total_reg != CNT_MAX)) ?
                    total_reg + 1'b1 : total_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    mag_next   = value[PCEP_MAG_W-1:0];
                    prime_next = 1'b0;
                    end_next   = (value == 32'sd0);
                    div_next   = PCEP_DIV_W'(2);
                    sq_next    = 32'd4;
                    if (value == 32'sd0 || value[31] || value[PCEP_MAG_W-1:0] <= 31'd1)
                        state_next = ST_DONE;
                    else
                        state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sq_reg > {1'b0, mag_reg})
                begin
                    prime_next = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    rem_ctrl.start = 1'b1;
                    state_next     = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (rem_stat.done)
                begin
                    if (rem_stat.zero)
                        state_next = ST_DONE;
                    else
                    begin
                        // (d+1)^2 = d^2 + 2d + 1
                        sq_next    = sq_reg + {15'd0, div_reg, 1'b1};
                        div_next   = div_reg + 1'b1;
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_pos_next   = pos_reg;
                    out_end_next   = end_reg;
                    if (end_reg)
                    begin
                        out_prime_next = 1'b0;
                        out_cnt_next   = total_reg;
                        pos_next       = '0;
                        total_next     = '0;
                    end
                    else
                    begin
                        out_prime_next = prime_reg;
                        out_cnt_next   = total_inc;
                        total_next     = total_inc;
                        if (pos_reg < POS_LIMIT)
                            pos_next = pos_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg       <= mag_next;
        div_reg       <= div_next;
        sq_reg        <= sq_next;
        prime_reg     <= prime_next;
        end_reg       <= end_next;
        out_prime_reg <= out_prime_next;
        out_pos_reg   <= out_pos_next;
        out_cnt_reg   <= out_cnt_next;
        out_end_reg   <= out_end_next;
    end

    assign out_valid   = out_valid_reg;
    assign is_prime    = out_prime_reg;
    assign position    = out_pos_reg;
    assign prime_count = out_cnt_reg;
    assign list_end    = out_end_reg;

    a_end_not_prime: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && list_end) |-> !is_prime)
        else $error("list end transfer flagged as prime");

    a_divide_has_unit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE) |-> (rem_stat.busy || rem_stat.done))
        else $error("waiting on an idle remainder unit");

    a_pos_limit: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_LIMIT)
        else $error("position counter past its limit");

    a_start_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
        rem_ctrl.start |-> (!rem_stat.busy && div_reg >= PCEP_DIV_W'(2)))
        else $error("remainder start while busy or with bad divisor");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && end_reg && (!out_valid_reg || out_ready))
        |=> (pos_reg == '0 && total_reg == '0))
        else $error("counters not cleared at list end");

endmodule
